[rtl/mcfd_pkg.sv]
package mcfd_pkg;

  localparam int unsigned LIMIT_W    = 31;
  localparam int unsigned MS_W       = 32;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  // Configuration register indexes.
  localparam logic CFG_SESSION_LIMIT   = 1'b0;
  localparam logic CFG_HEARTBEAT_LIMIT = 1'b1;

  localparam logic [LIMIT_W-1:0] SESSION_LIMIT_RST   = 31'd30000;
  localparam logic [LIMIT_W-1:0] HEARTBEAT_LIMIT_RST = 31'd1000;

  // Item kinds carried in tuser.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Framing bytes.
  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam logic [7:0] BYTE_START = 8'h74; // 't'
  localparam logic [7:0] BYTE_SYNC  = 8'h71; // 'q'
  localparam logic [7:0] BYTE_END   = 8'h65; // 'e'

  // Frame positions.
  localparam logic [POS_W-1:0] POS_IDLE      = 4'd0;
  localparam logic [POS_W-1:0] POS_SYNC      = 4'd1;
  localparam logic [POS_W-1:0] POS_PAY_FIRST = 4'd2;
  localparam logic [POS_W-1:0] POS_PAY_STORE = 4'd6;
  localparam logic [POS_W-1:0] POS_END       = 4'd8;

  // One-letter commands.
  localparam logic [7:0] CMD_THR_UP   = 8'h3D; // '='
  localparam logic [7:0] CMD_THR_DOWN = 8'h2D; // '-'
  localparam logic [7:0] CMD_STOP     = 8'h30; // '0'
  localparam logic [7:0] CMD_MODE_LO  = 8'h31; // '1'
  localparam logic [7:0] CMD_MODE_HI  = 8'h36; // '6'
  localparam logic [7:0] CMD_GYRO     = 8'h67; // 'g'
  localparam logic [7:0] CMD_THR_ZERO = 8'h76; // 'v'
  localparam logic [7:0] CMD_ARM      = 8'h6D; // 'm'
  localparam logic [7:0] CMD_BEAT     = 8'h63; // 'c'

  localparam logic [THR_W-1:0] THR_STEP_UP   = 16'sd50;
  localparam logic [THR_W-1:0] THR_STEP_DOWN = 16'sd10;
  localparam logic [THR_W-1:0] THR_ARMED     = -16'sd10;
  localparam logic [7:0]       THR_BYTE_MAX  = 8'd100;

  typedef struct packed {
    logic            req_type;
    logic [7:0]      rx_byte;
    logic [MS_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic              gyro_cal_start;
    logic              stop_motors;
    logic              armed_out;
    logic [2:0]        mode_out;
    logic signed [7:0] desired_y_out;
    logic signed [7:0] desired_x_out;
    logic signed [THR_W-1:0] throttle_out;
  } result_t;

endpackage

[rtl/mcfd_core.sv]
module mcfd_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_addr,
  input  logic [mcfd_pkg::LIMIT_W-1:0]   cfg_wdata,
  input  logic                           step,
  input  mcfd_pkg::item_t                item,
  output mcfd_pkg::result_t              res
);

  logic [mcfd_pkg::LIMIT_W-1:0] session_limit_r;
  logic [mcfd_pkg::LIMIT_W-1:0] heartbeat_limit_r;

  logic [mcfd_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]                 pay_r [4];
  logic [7:0]                 pay_nxt [4];
  logic signed [mcfd_pkg::THR_W-1:0] thr_r, thr_nxt;
  logic signed [7:0]          x_r, x_nxt;
  logic signed [7:0]          y_r, y_nxt;
  logic [2:0]                 mode_r, mode_nxt;
  logic                       armed_r, armed_nxt;
  logic [mcfd_pkg::MS_W-1:0]  session_r, session_nxt;
  logic [mcfd_pkg::MS_W-1:0]  beat_r, beat_nxt;
  logic                       stop, gyro;

  logic [mcfd_pkg::MS_W-1:0]  session_age, beat_age;
  logic signed [mcfd_pkg::THR_W:0] thr_up, thr_down;
  logic signed [mcfd_pkg::THR_W-1:0] thr_up_sat, thr_down_sat, thr_cmd;
  logic [7:0]                 cmd;
  logic [mcfd_pkg::THR_W-1:0] thr_byte;
  logic [7:0]                 x_fix, y_fix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_limit_r   <= mcfd_pkg::SESSION_LIMIT_RST;
      heartbeat_limit_r <= mcfd_pkg::HEARTBEAT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        mcfd_pkg::CFG_SESSION_LIMIT:   session_limit_r   <= cfg_wdata;
        mcfd_pkg::CFG_HEARTBEAT_LIMIT: heartbeat_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Elapsed times wrap modulo 2^32 like the millisecond counter.
  assign session_age = item.now_ms - session_r;
  assign beat_age    = item.now_ms - beat_r;

  // Saturating throttle steps: one extra bit holds the overflow.
  assign thr_up   = {thr_r[mcfd_pkg::THR_W-1], thr_r} +
                    {1'b0, mcfd_pkg::THR_STEP_UP};
  assign thr_down = {thr_r[mcfd_pkg::THR_W-1], thr_r} -
                    {1'b0, mcfd_pkg::THR_STEP_DOWN};
  assign thr_up_sat   = (thr_up[mcfd_pkg::THR_W] != thr_up[mcfd_pkg::THR_W-1]) ?
                        16'sh7FFF : thr_up[mcfd_pkg::THR_W-1:0];
  assign thr_down_sat = (thr_down[mcfd_pkg::THR_W] != thr_down[mcfd_pkg::THR_W-1]) ?
                        16'sh8000 : thr_down[mcfd_pkg::THR_W-1:0];

  assign cmd      = pay_r[0];
  assign thr_byte = {5'd0, pay_r[1], 3'd0} + {7'd0, pay_r[1], 1'b0};
  // Negative setpoints are raised by one.
  assign x_fix    = pay_r[2] + {7'd0, pay_r[2][7]};
  assign y_fix    = pay_r[3] + {7'd0, pay_r[3][7]};

  always_comb begin
    case (cmd)
      mcfd_pkg::CMD_THR_UP:   thr_cmd = thr_up_sat;
      mcfd_pkg::CMD_THR_DOWN: thr_cmd = thr_down_sat;
      mcfd_pkg::CMD_THR_ZERO: thr_cmd = '0;
      mcfd_pkg::CMD_ARM:      thr_cmd = mcfd_pkg::THR_ARMED;
      default:                thr_cmd = thr_r;
    endcase
  end

  always_comb begin
    pos_nxt     = pos_r;
    pay_nxt     = pay_r;
    thr_nxt     = thr_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    mode_nxt    = mode_r;
    armed_nxt   = armed_r;
    session_nxt = session_r;
    beat_nxt    = beat_r;
    stop        = 1'b0;
    gyro        = 1'b0;

    if (item.req_type == mcfd_pkg::REQ_TICK) begin
      if (session_age > {1'b0, session_limit_r} || beat_age > {1'b0, heartbeat_limit_r}) begin
        armed_nxt = 1'b0;
      end
      stop = !armed_nxt;
    end else if (item.rx_byte != mcfd_pkg::BYTE_IDLE) begin
      if (pos_r == mcfd_pkg::POS_IDLE && item.rx_byte == mcfd_pkg::BYTE_START) begin
        pos_nxt = mcfd_pkg::POS_SYNC;
      end else if (pos_r == mcfd_pkg::POS_SYNC && item.rx_byte == mcfd_pkg::BYTE_SYNC) begin
        pos_nxt = mcfd_pkg::POS_PAY_FIRST;
      end else if (pos_r >= mcfd_pkg::POS_PAY_FIRST && pos_r < mcfd_pkg::POS_END) begin
        if (pos_r < mcfd_pkg::POS_PAY_STORE) begin
          pay_nxt[pos_r[1:0] - 2'd2] = item.rx_byte;
        end
        pos_nxt = pos_r + 4'd1;
      end else if (pos_r == mcfd_pkg::POS_END && item.rx_byte == mcfd_pkg::BYTE_END) begin
        pos_nxt = mcfd_pkg::POS_IDLE;
        thr_nxt = thr_cmd;
        case (cmd)
          mcfd_pkg::CMD_STOP: begin
            stop      = 1'b1;
            armed_nxt = 1'b0;
          end
          mcfd_pkg::CMD_GYRO: gyro = 1'b1;
          mcfd_pkg::CMD_ARM: begin
            armed_nxt   = 1'b1;
            session_nxt = item.now_ms;
          end
          mcfd_pkg::CMD_BEAT: beat_nxt = item.now_ms;
          default: ;
        endcase
        if (cmd >= mcfd_pkg::CMD_MODE_LO && cmd <= mcfd_pkg::CMD_MODE_HI) begin
          mode_nxt = cmd[2:0] - mcfd_pkg::CMD_MODE_LO[2:0];
        end
        if (pay_r[1] <= mcfd_pkg::THR_BYTE_MAX) begin
          thr_nxt = thr_byte;
        end
        x_nxt      = x_fix;
        y_nxt      = y_fix;
        pay_nxt[2] = x_fix;
        pay_nxt[3] = y_fix;
      end else begin
        pos_nxt = mcfd_pkg::POS_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= mcfd_pkg::POS_IDLE;
      pay_r     <= '{default: 8'd0};
      thr_r     <= '0;
      x_r       <= '0;
      y_r       <= '0;
      mode_r    <= '0;
      armed_r   <= 1'b0;
      session_r <= '0;
      beat_r    <= '0;
    end else if (step) begin
      pos_r     <= pos_nxt;
      pay_r     <= pay_nxt;
      thr_r     <= thr_nxt;
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      mode_r    <= mode_nxt;
      armed_r   <= armed_nxt;
      session_r <= session_nxt;
      beat_r    <= beat_nxt;
    end
  end

  assign res.throttle_out   = thr_nxt;
  assign res.desired_x_out  = x_nxt;
  assign res.desired_y_out  = y_nxt;
  assign res.mode_out       = mode_nxt;
  assign res.armed_out      = armed_nxt;
  assign res.stop_motors    = stop;
  assign res.gyro_cal_start = gyro;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= mcfd_pkg::POS_END)
    else $error("frame position out of range");

  a_gyro_byte_only: assert property (@(posedge clk) disable iff (!rst_n)
    gyro |-> (item.req_type == mcfd_pkg::REQ_BYTE && pos_r == mcfd_pkg::POS_END))
    else $error("gyro pulse outside a completed frame");

  a_tick_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (item.req_type == mcfd_pkg::REQ_TICK) |-> (stop == !armed_nxt))
    else $error("tick stop flag disagrees with armed state");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r <= 3'd5)
    else $error("mode out of range");

  a_arm_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !armed_r && armed_nxt) |=> (session_r == $past(item.now_ms)))
    else $error("arming did not stamp the session start");

endmodule

[rtl/motor_command_frame_decoder_unit.sv]
// Motor command frame decoder.
// The in_ channel carries one item per handshake: a received serial byte
// (in_tuser low) or a periodic safety tick (in_tuser high), each with the
// current millisecond count. Bytes assemble frames of 't', 'q', six payload
// bytes and 'e'; a complete frame applies a command, throttle and setpoints.
// A tick disarms the block on a session or heartbeat timeout.
// Every accepted item produces exactly one result item on the out_ channel
// carrying the current throttle, setpoints, mode, armed state and pulses.
// The cfg_ port writes one of the two timeout limits per cycle; write it
// only while no item is in flight.
// The accepting edge loads the input register; the result is written into
// the output register once that register is empty or being read. One item
// per cycle is sustained while the receiver takes every result; the per-item
// update is a single pass of logic on the state.
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more item; in_tready then drops.
// Reset (rst_n low at a clock edge) clears the frame and control state,
// restores the default limits and empties both registers.
module motor_command_frame_decoder_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic                               cfg_addr,
  input  logic [mcfd_pkg::LIMIT_W-1:0]       cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] rx_byte, [39:8] now_ms
  input  logic [mcfd_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] req_type
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] throttle_out, [23:16] desired_x_out, [31:24] desired_y_out,
  // [34:32] mode_out, [35] armed_out, [36] stop_motors, [37] gyro_cal_start
  output logic [mcfd_pkg::OUT_DATA_W-1:0]    out_tdata
);

  logic              in_vld_r;
  mcfd_pkg::item_t   item_r;
  logic              out_vld_r;
  mcfd_pkg::result_t res_r;
  mcfd_pkg::result_t res;
  logic              advance;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.req_type <= in_tuser;
      item_r.rx_byte  <= in_tdata[7:0];
      item_r.now_ms   <= in_tdata[39:8];
    end
  end

  mcfd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .item      (item_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, res_r};

endmodule

[test/motor_command_frame_decoder_unit_test.sv]
`timescale 1ns / 1ps

module motor_command_frame_decoder_unit_test;
  import mcfd_pkg::*;

  // Axis nudges; the setpoint bytes of the same frame overwrite them.
  localparam logic [7:0] CMD_X_DOWN = 8'h61; // 'a'
  localparam logic [7:0] CMD_X_UP   = 8'h64; // 'd'
  localparam logic [7:0] CMD_Y_DOWN = 8'h73; // 's'
  localparam logic [7:0] CMD_Y_UP   = 8'h77; // 'w'

  localparam logic [THR_W-1:0]   THR_BYTE_SCALE = 16'd10;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX      = '1;
  localparam int                 CHOKE_CYCLES   = 60;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [31:0] now;
    logic        typed;
    result_t     want;
  } probe_t;

  // Hand-written expectations only where they are obvious; the other rows
  // take the decoder prediction.
  localparam probe_t PROBES [25] = '{
    '{REQ_TICK, 8'h00,       32'd0,    1'b1,
      '{1'b0, 1'b1, 1'b0, 3'd0, 8'sd0, 8'sd0, 16'sd0}},
    '{REQ_BYTE, BYTE_IDLE,   32'd5,    1'b1, '0},
    '{REQ_BYTE, BYTE_START,  32'd500,  1'b0, '0},
    '{REQ_BYTE, BYTE_SYNC,   32'd500,  1'b0, '0},
    '{REQ_BYTE, CMD_ARM,     32'd500,  1'b0, '0},
    '{REQ_BYTE, 8'd100,      32'd500,  1'b0, '0},
    '{REQ_BYTE, 8'h80,       32'd500,  1'b0, '0},
    '{REQ_BYTE, BYTE_IDLE,   32'd500,  1'b0, '0},
    '{REQ_BYTE, 8'h7F,       32'd500,  1'b0, '0},
    '{REQ_BYTE, 8'h00,       32'd500,  1'b0, '0},
    '{REQ_BYTE, 8'h00,       32'd500,  1'b0, '0},
    '{REQ_BYTE, BYTE_END,    32'd500,  1'b1,
      '{1'b0, 1'b0, 1'b1, 3'd0, 8'sd127, -8'sd127, 16'sd1000}},
    '{REQ_TICK, 8'h00,       32'd1000, 1'b1,
      '{1'b0, 1'b0, 1'b1, 3'd0, 8'sd127, -8'sd127, 16'sd1000}},
    '{REQ_TICK, 8'h00,       32'd1001, 1'b1,
      '{1'b0, 1'b1, 1'b0, 3'd0, 8'sd127, -8'sd127, 16'sd1000}},
    '{REQ_BYTE, BYTE_START,  32'd1200, 1'b0, '0},
    '{REQ_BYTE, BYTE_START,  32'd1200, 1'b0, '0},
    '{REQ_BYTE, BYTE_START,  32'd1500, 1'b0, '0},
    '{REQ_BYTE, BYTE_SYNC,   32'd1500, 1'b0, '0},
    '{REQ_BYTE, CMD_GYRO,    32'd1500, 1'b0, '0},
    '{REQ_BYTE, 8'd101,      32'd1500, 1'b0, '0},
    '{REQ_BYTE, 8'h81,       32'd1500, 1'b0, '0},
    '{REQ_BYTE, 8'h00,       32'd1500, 1'b0, '0},
    '{REQ_BYTE, 8'h55,       32'd1500, 1'b0, '0},
    '{REQ_BYTE, 8'hAA,       32'd1500, 1'b0, '0},
    '{REQ_BYTE, BYTE_END,    32'd1500, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic                  cfg_addr;
  logic [LIMIT_W-1:0]    cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [7:0] rx_byte, [39:8] now_ms
  logic                  in_tuser;   // [0] req_type
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [15:0] throttle_out, [23:16] desired_x_out, [31:24] desired_y_out,
  // [34:32] mode_out, [35] armed_out, [36] stop_motors, [37] gyro_cal_start
  logic [OUT_DATA_W-1:0] out_tdata;

  motor_command_frame_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // Decoder state as the block should hold it.
  logic [POS_W-1:0]        frame_at;
  logic [7:0]              payload [4];
  logic signed [THR_W-1:0] throttle;
  logic signed [7:0]       set_x;
  logic signed [7:0]       set_y;
  logic [2:0]              mode;
  logic                    armed;
  logic [MS_W-1:0]         sess_stamp;
  logic [MS_W-1:0]         beat_stamp;
  logic [LIMIT_W-1:0]      sess_lim;
  logic [LIMIT_W-1:0]      beat_lim;

  result_t         status_due [$];
  int              err_count = 0;
  int              results_checked = 0;
  int              items_sent = 0;
  int              frames_done = 0;
  int              ticks_seen = 0;
  int              forced_disarms = 0;
  int              gyro_pulses = 0;
  int              tx_busy_pct = 30;
  bit              rush = 1'b0;
  logic            choke_req;
  logic [MS_W-1:0] clock_ms;

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  function automatic int idle_share();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic logic signed [THR_W-1:0] sat_throttle(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  task automatic decode_item(input logic kind, input logic [7:0] b,
                             input logic [MS_W-1:0] now, output result_t r);
    logic [MS_W-1:0]   age_s;
    logic [MS_W-1:0]   age_b;
    logic              stop;
    logic              gyro;
    logic signed [7:0] px;
    logic signed [7:0] py;
    begin
      stop = 1'b0;
      gyro = 1'b0;
      if (kind == REQ_TICK) begin
        ticks_seen++;
        // Elapsed times wrap with the millisecond counter.
        age_s = now - sess_stamp;
        age_b = now - beat_stamp;
        if (armed && (age_s > sess_lim || age_b > beat_lim)) forced_disarms++;
        if (age_s > sess_lim) armed = 1'b0;
        if (age_b > beat_lim) armed = 1'b0;
        stop = !armed;
      end else if (b != BYTE_IDLE) begin
        if (frame_at == POS_IDLE && b == BYTE_START) begin
          frame_at = POS_SYNC;
        end else if (frame_at == POS_SYNC && b == BYTE_SYNC) begin
          frame_at = POS_PAY_FIRST;
        end else if (frame_at >= POS_PAY_FIRST && frame_at < POS_END) begin
          if (frame_at < POS_PAY_STORE) payload[2'(frame_at - POS_PAY_FIRST)] = b;
          frame_at = frame_at + 4'd1;
        end else if (frame_at == POS_END && b == BYTE_END) begin
          frame_at = POS_IDLE;
          frames_done++;
          case (payload[0])
            CMD_THR_UP:   throttle = sat_throttle(int'(throttle) + int'(THR_STEP_UP));
            CMD_THR_DOWN: throttle = sat_throttle(int'(throttle) - int'(THR_STEP_DOWN));
            CMD_STOP: begin
              stop = 1'b1;
              armed = 1'b0;
            end
            CMD_X_DOWN:   set_x = set_x - 8'sd1;
            CMD_X_UP:     set_x = set_x + 8'sd1;
            CMD_Y_DOWN:   set_y = set_y - 8'sd1;
            CMD_Y_UP:     set_y = set_y + 8'sd1;
            CMD_GYRO:     gyro = 1'b1;
            CMD_THR_ZERO: throttle = '0;
            CMD_ARM: begin
              throttle = THR_ARMED;
              armed = 1'b1;
              sess_stamp = now;
            end
            CMD_BEAT:     beat_stamp = now;
            default: begin
              if (payload[0] >= CMD_MODE_LO && payload[0] <= CMD_MODE_HI)
                mode = 3'(payload[0] - CMD_MODE_LO);
            end
          endcase
          // Bytes above THR_BYTE_MAX (100) leave the throttle alone.
          if (payload[1] <= THR_BYTE_MAX) throttle = 16'(payload[1]) * THR_BYTE_SCALE;
          px = payload[2];
          py = payload[3];
          if (px < 0) px = px + 8'sd1;
          if (py < 0) py = py + 8'sd1;
          set_x = px;
          set_y = py;
          if (gyro) gyro_pulses++;
        end else begin
          frame_at = POS_IDLE;
        end
      end
      r.throttle_out   = throttle;
      r.desired_x_out  = set_x;
      r.desired_y_out  = set_y;
      r.mode_out       = mode;
      r.armed_out      = armed;
      r.stop_motors    = stop;
      r.gyro_cal_start = gyro;
    end
  endtask

  task automatic flag_mismatch(input string what, input logic signed [31:0] got,
                               input logic signed [31:0] want);
    err_count++;
    $display("%0d ns: result %0d: %s %0d, predicted %0d",
             $time, results_checked, what, got, want);
  endtask

  task automatic match_status(input result_t got);
    result_t want;
    begin
      results_checked++;
      if (status_due.size() == 0) begin
        flag_mismatch("result with no item pending, throttle_out", got.throttle_out, 0);
      end else begin
        want = status_due.pop_front();
        if (got.throttle_out !== want.throttle_out)
          flag_mismatch("throttle_out", got.throttle_out, want.throttle_out);
        if (got.desired_x_out !== want.desired_x_out)
          flag_mismatch("desired_x_out", got.desired_x_out, want.desired_x_out);
        if (got.desired_y_out !== want.desired_y_out)
          flag_mismatch("desired_y_out", got.desired_y_out, want.desired_y_out);
        if (got.mode_out !== want.mode_out)
          flag_mismatch("mode_out", got.mode_out, want.mode_out);
        if (got.armed_out !== want.armed_out)
          flag_mismatch("armed_out", got.armed_out, want.armed_out);
        if (got.stop_motors !== want.stop_motors)
          flag_mismatch("stop_motors", got.stop_motors, want.stop_motors);
        if (got.gyro_cal_start !== want.gyro_cal_start)
          flag_mismatch("gyro_cal_start", got.gyro_cal_start, want.gyro_cal_start);
      end
    end
  endtask

  // Result side: takes results and stalls at random, plus one long hold-off
  // on request so the block backs up into its input.
  int stall_left = 0;
  int rx_busy_pct = 20;
  int rx_seg = 0;
  bit choke_done = 1'b0;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) match_status(result_t'(out_tdata[37:0]));
    if (choke_req && !choke_done) begin
      choke_done = 1'b1;
      stall_left = CHOKE_CYCLES;
    end
    if (rx_seg == 0) begin
      rx_seg = $urandom_range(20, 80);
      rx_busy_pct = idle_share();
    end
    rx_seg--;
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < rx_busy_pct) begin
      stall_left = gap_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] b, input logic [MS_W-1:0] now);
    int      idle;
    result_t r;
    begin
      idle = 0;
      if (!rush && $urandom_range(0, 99) < tx_busy_pct) idle = gap_len();
      if (idle > 0) begin
        in_tvalid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tuser  <= kind;
      in_tdata  <= {now, b};
      do @(posedge clk); while (!in_tready);
      decode_item(kind, b, now, r);
      status_due.push_back(r);
      if (kind == REQ_TICK || b != BYTE_IDLE) items_sent++;
    end
  endtask

  task automatic set_limits(input logic [LIMIT_W-1:0] session, input logic [LIMIT_W-1:0] beat);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_SESSION_LIMIT;
    cfg_wdata <= session;
    @(posedge clk);
    cfg_addr  <= CFG_HEARTBEAT_LIMIT;
    cfg_wdata <= beat;
    @(posedge clk);
    cfg_we <= 1'b0;
    sess_lim = session;
    beat_lim = beat;
  endtask

  task automatic wait_drained();
    int n;
    begin
      n = 0;
      in_tvalid <= 1'b0;
      while (status_due.size() != 0 && n < 20000) begin
        @(posedge clk);
        n++;
      end
    end
  endtask

  task automatic run_random(input int count);
    int         base;
    int         cut;
    int         i;
    logic [7:0] frame [9];
    begin
      base = items_sent;
      while (items_sent - base < count) begin
        if ($urandom_range(0, 29) == 0) tx_busy_pct = idle_share();
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            frame[0] = BYTE_START;
            frame[1] = BYTE_SYNC;
            case ($urandom_range(0, 17))
              0:         frame[2] = CMD_THR_UP;
              1:         frame[2] = CMD_THR_DOWN;
              2:         frame[2] = CMD_STOP;
              3:         frame[2] = CMD_MODE_LO + 8'($urandom_range(0, 5));
              4:         frame[2] = CMD_GYRO;
              5:         frame[2] = CMD_THR_ZERO;
              6, 7, 8:   frame[2] = CMD_ARM;
              9, 10, 11: frame[2] = CMD_BEAT;
              12:        frame[2] = CMD_X_DOWN;
              13:        frame[2] = CMD_X_UP;
              14:        frame[2] = CMD_Y_DOWN;
              15:        frame[2] = CMD_Y_UP;
              default:   frame[2] = 8'($urandom_range(0, 254));
            endcase
            case ($urandom_range(0, 4))
              0:       frame[3] = 8'($urandom_range(0, 100));
              1:       frame[3] = 8'(100 + $urandom_range(0, 1));
              2:       frame[3] = 8'($urandom_range(0, 254));
              default: frame[3] = 8'hC8;
            endcase
            for (i = 4; i < 8; i++) frame[i] = 8'($urandom_range(0, 254));
            frame[8] = BYTE_END;
            // One frame in five is cut short or closed by a wrong byte.
            cut = 9;
            if ($urandom_range(0, 4) == 0) cut = $urandom_range(0, 1) ? 8 : $urandom_range(1, 7);
            for (i = 0; i < cut; i++) begin
              if ($urandom_range(0, 24) == 0) send_item(REQ_BYTE, BYTE_IDLE, clock_ms);
              send_item(REQ_BYTE, frame[i], clock_ms);
              clock_ms += $urandom_range(0, 2);
            end
            if (cut < 9) send_item(REQ_BYTE, 8'($urandom_range(0, 255)), clock_ms);
          end
          6, 7, 8: begin
            case ($urandom_range(0, 7))
              0:       clock_ms += $urandom();
              1:       clock_ms = beat_stamp + beat_lim + 32'($urandom_range(0, 1));
              2:       clock_ms = sess_stamp + sess_lim + 32'($urandom_range(0, 1));
              default: clock_ms += $urandom_range(0, 400);
            endcase
            send_item(REQ_TICK, 8'($urandom_range(0, 255)), clock_ms);
          end
          default: send_item(REQ_BYTE, 8'($urandom_range(0, 255)), clock_ms);
        endcase
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int ph;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_SESSION_LIMIT;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = REQ_BYTE;
    choke_req = 1'b0;
    clock_ms  = '0;
    frame_at   = POS_IDLE;
    payload    = '{default: 8'h00};
    throttle   = '0;
    set_x      = '0;
    set_y      = '0;
    mode       = '0;
    armed      = 1'b0;
    sess_stamp = '0;
    beat_stamp = '0;
    sess_lim   = SESSION_LIMIT_RST;
    beat_lim   = HEARTBEAT_LIMIT_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PROBES[i]) begin
      send_item(PROBES[i].kind, PROBES[i].data, PROBES[i].now);
      if (PROBES[i].typed) status_due[$] = PROBES[i].want;
    end

    for (ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0:       set_limits('0, '0);
        1:       set_limits(LIMIT_MAX, LIMIT_MAX);
        2:       set_limits(31'($urandom_range(0, 5000)), 31'($urandom_range(0, 2000)));
        default: set_limits(SESSION_LIMIT_RST, HEARTBEAT_LIMIT_RST);
      endcase
      clock_ms = $urandom();
      if (ph == 0) begin
        // Back-to-back items against a long receiver stall.
        rush = 1'b1;
        choke_req <= 1'b1;
        run_random(14);
        rush = 1'b0;
        run_random(86);
      end else begin
        run_random(100);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (status_due.size() != 0) flag_mismatch("results never delivered", status_due.size(), 0);

    $display("Sent %0d items, %0d full frames, %0d ticks, %0d timeout disarms, %0d gyro pulses.",
             items_sent, frames_done, ticks_seen, forced_disarms, gyro_pulses);
    $display("Limits ran at reset values, zero, maximum and random; %0d results checked, %0d errors.",
             results_checked, err_count);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
